FILE: hw/rtl/sgcd_pkg.sv
// Shared types and constants of the signed integer GCD block.
package sgcd_pkg;

  // Fixed widths of the operand and divisor ports.
  localparam int unsigned OperandW = 64;
  localparam int unsigned DivisorW = 63;

  // Status of the GCD core as seen by the handshake logic.
  typedef struct packed {
    logic idle;  // ready to load a new pair of magnitudes
    logic done;  // result is valid and waits to be taken
  } sgcd_stat_t;

endpackage

FILE: hw/rtl/signed_integer_gcd.sv
// An item is loaded, run through binary GCD steps in the sequencer, then registered at the output.
// The shared subtract/compare unit retires one halving or one subtract-and-halve per cycle;
// an operand of zero skips the steps and gives a divisor of one.
// One item at a time; a new one is taken once the result has moved to the output register.
// Reset: asynchronous, active low; clears handshake and sequencer state, not data.
module signed_integer_gcd #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sgcd_pkg::OperandW-1:0] operand_a_i,
  input  logic [sgcd_pkg::OperandW-1:0] operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sgcd_pkg::DivisorW-1:0] divisor_o
);

  localparam int unsigned MagW = DATA_WIDTH - 1;

  logic [MagW-1:0]              mag_a;
  logic [MagW-1:0]              mag_b;
  logic [MagW-1:0]              core_res;
  sgcd_pkg::sgcd_stat_t         core_stat;
  logic                         start;
  logic                         take;
  logic                         out_valid_q, out_valid_d;
  logic [sgcd_pkg::DivisorW-1:0] divisor_q;

  // Fold both operands to magnitudes in the load cycle.
  sgcd_abs #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_abs_a (
    .raw_i(operand_a_i),
    .mag_o(mag_a)
  );

  sgcd_abs #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_abs_b (
    .raw_i(operand_b_i),
    .mag_o(mag_b)
  );

  // Accept an item whenever the sequencer is idle.
  assign in_stall_o = !core_stat.idle;
  assign start      = in_valid_i && core_stat.idle;

  sgcd_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ack_i   (take),
    .mag_a_i (mag_a),
    .mag_b_i (mag_b),
    .result_o(core_res),
    .stat_o  (core_stat)
  );

  // Move the finished divisor into the output register once it is free or draining.
  assign take = core_stat.done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload while stalled; zero-extend the magnitude to the port width.
  always_ff @(posedge clk_i) begin
    if (take) begin
      divisor_q <= sgcd_pkg::DivisorW'(core_res);
    end
  end

  assign out_valid_o = out_valid_q;
  assign divisor_o   = divisor_q;

endmodule

FILE: hw/rtl/sgcd_abs.sv
// Magnitude of a two's complement operand, saturated to the positive range.
module sgcd_abs #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic [sgcd_pkg::OperandW-1:0] raw_i,
  output logic [DATA_WIDTH-2:0]         mag_o
);

  logic [DATA_WIDTH-1:0] val;
  logic [DATA_WIDTH-1:0] neg;
  logic [DATA_WIDTH-1:0] sign_only;

  assign val       = raw_i[DATA_WIDTH-1:0];
  assign neg       = ~val + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  assign sign_only = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  always_comb begin
    priority if (!val[DATA_WIDTH-1]) begin
      mag_o = val[DATA_WIDTH-2:0];
    end else if (val == sign_only) begin
      // most negative value saturates to the largest magnitude
      mag_o = {(DATA_WIDTH-1){1'b1}};
    end else begin
      mag_o = neg[DATA_WIDTH-2:0];
    end
  end

endmodule

FILE: hw/rtl/sgcd_sub.sv
// Shared subtract and compare unit: absolute difference and ordering.
module sgcd_sub #(
  parameter int unsigned MAG_WIDTH = 63
) (
  input  logic [MAG_WIDTH-1:0] a_i,
  input  logic [MAG_WIDTH-1:0] b_i,
  output logic [MAG_WIDTH-1:0] diff_o,
  output logic                 a_gt_b_o,
  output logic                 eq_o
);

  logic [MAG_WIDTH:0]   diff_ab;
  logic [MAG_WIDTH-1:0] diff_ba;

  assign diff_ab  = {1'b0, a_i} - {1'b0, b_i};
  assign diff_ba  = b_i - a_i;
  assign eq_o     = (a_i == b_i);
  assign a_gt_b_o = !diff_ab[MAG_WIDTH] && !eq_o;
  assign diff_o   = diff_ab[MAG_WIDTH] ? diff_ba : diff_ab[MAG_WIDTH-1:0];

endmodule

FILE: hw/rtl/sgcd_core.sv
// Binary GCD sequencer around one shared subtract and compare unit.
module sgcd_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   ack_i,
  input  logic [DATA_WIDTH-2:0]  mag_a_i,
  input  logic [DATA_WIDTH-2:0]  mag_b_i,
  output logic [DATA_WIDTH-2:0]  result_o,
  output sgcd_pkg::sgcd_stat_t   stat_o
);

  localparam int unsigned MagW = DATA_WIDTH - 1;
  localparam int unsigned ShW  = $clog2(MagW);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [MagW-1:0] a_q, a_d;
  logic [MagW-1:0] b_q, b_d;
  logic [ShW-1:0]  k_q, k_d;

  logic [MagW-1:0] diff;
  logic            a_gt_b;
  logic            eq;

  sgcd_sub #(
    .MAG_WIDTH(MagW)
  ) u_sub (
    .a_i     (a_q),
    .b_i     (b_q),
    .diff_o  (diff),
    .a_gt_b_o(a_gt_b),
    .eq_o    (eq)
  );

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          k_d = '0;
          if (mag_a_i == '0 || mag_b_i == '0) begin
            // zero magnitude: answer is one
            a_d     = {{(MagW-1){1'b0}}, 1'b1};
            state_d = StDone;
          end else begin
            a_d     = mag_a_i;
            b_d     = mag_b_i;
            state_d = StRun;
          end
        end
      end
      StRun: begin
        priority if (eq) begin
          state_d = StDone;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + {{(ShW-1){1'b0}}, 1'b1};
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_gt_b) begin
          a_d = diff >> 1;
        end else begin
          b_d = diff >> 1;
        end
      end
      StDone: begin
        if (ack_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  assign result_o    = a_q << k_q;
  assign stat_o.idle = (state_q == StIdle);
  assign stat_o.done = (state_q == StDone);

`ifndef ASSERT_OFF
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> (a_q != '0 && b_q != '0))
    else $error("operand reached zero during iteration");

  a_done_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |-> a_q != '0)
    else $error("zero divisor at completion");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> int'(k_q) < int'(MagW))
    else $error("common power of two out of range");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == StIdle)
    else $error("start while busy");
`endif

endmodule

FILE: tb/signed_integer_gcd_tb.sv
// Self-checking testbench for the signed integer GCD block.
`timescale 1ns / 1ps

module signed_integer_gcd_tb;

  localparam int unsigned OPW = sgcd_pkg::OperandW;
  localparam int unsigned DVW = sgcd_pkg::DivisorW;

  // Signed extremes and corner values of the operand and divisor ports.
  localparam logic [OPW-1:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OPW-1:0] NEG_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [OPW-1:0] NEG_MAX  = 64'h8000_0000_0000_0001;
  localparam logic [OPW-1:0] MINUS_1  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [OPW-1:0] TWO_P62  = 64'h4000_0000_0000_0000;
  localparam logic [DVW-1:0] DIV_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DVW-1:0] DIV_ONE  = 63'd1;

  // Run shape: random pairs per phase, receiver hold-off length, drain tail, timeout.
  localparam int PHASES        = 7;
  localparam int PAIRS_PER     = 200;
  localparam int QUIET_PHASE   = 1;
  localparam int HOLD_PHASE    = 2;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_500_000;

  // Kinds of random operand pairs.
  typedef enum int {
    PK_FULL,
    PK_COMMON,
    PK_MULTIPLE,
    PK_SMALL,
    PK_CORNER,
    PK_FIBONACCI,
    PK_SHIFTED,
    PK_COUNT
  } pair_kind_e;

  // One row of the directed table; a typed divisor is checked as written.
  typedef struct packed {
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    bit             typed;
    logic [DVW-1:0] divisor;
  } gcd_row_t;

  logic           clk        = 1'b0;
  logic           rst_n      = 1'b0;
  logic           in_valid   = 1'b0;
  logic           in_stall;
  logic [OPW-1:0] operand_a  = '0;
  logic [OPW-1:0] operand_b  = '0;
  logic           out_valid;
  logic           out_stall  = 1'b0;
  logic [DVW-1:0] divisor;

  // Side info that travels with the offered item: typed divisor of a table row.
  bit             row_typed    = 1'b0;
  logic [DVW-1:0] row_divisor  = '0;

  logic [DVW-1:0] pending_divisors [$];
  logic [DVW-1:0] oldest_divisor;
  gcd_row_t       gcd_rows [$];
  logic [OPW-1:0] fib [0:92];
  logic [OPW-1:0] corner_vals [0:6];

  int  mismatches    = 0;
  int  items_taken   = 0;
  int  divisors_seen = 0;
  int  cycles        = 0;
  int  hold_asks     = 0;
  int  hold_seen     = 0;
  int  stall_left    = 0;
  bit  idling_on     = 1'b0;

  signed_integer_gcd dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operand_a_i (operand_a),
    .operand_b_i (operand_b),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .divisor_o   (divisor)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of a two's complement operand; the most negative value saturates.
  function automatic logic [OPW-1:0] saturated_magnitude(input logic [OPW-1:0] raw);
    logic [OPW-1:0] mag;
    begin
      mag = raw;
      if (raw[OPW-1]) begin
        mag = ~raw + 64'd1;
        if (mag == NEG_MIN) mag = POS_MAX;
      end
      return mag;
    end
  endfunction

  // Divisor of a pair: 1 when either magnitude is zero, else Euclid's
  // remainder steps until the remainder is 0 (answer is the divisor) or 1.
  function automatic logic [DVW-1:0] expected_divisor(input logic [OPW-1:0] a,
                                                      input logic [OPW-1:0] b);
    logic [OPW-1:0] greater;
    logic [OPW-1:0] lesser;
    logic [OPW-1:0] rem;
    begin
      greater = saturated_magnitude(a);
      lesser  = saturated_magnitude(b);
      if (greater < lesser) begin
        rem     = greater;
        greater = lesser;
        lesser  = rem;
      end
      while (lesser != 0) begin
        rem = greater % lesser;
        if (rem == 0) return lesser[DVW-1:0];
        if (rem == 1) return DIV_ONE;
        greater = lesser;
        lesser  = rem;
      end
      return DIV_ONE;
    end
  endfunction

  function automatic logic [OPW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OPW-1:0] low_mask(input int unsigned bits);
    return (64'd1 << bits) - 64'd1;
  endfunction

  function automatic logic [OPW-1:0] maybe_negate(input logic [OPW-1:0] v);
    return $urandom_range(0, 1) ? (~v + 64'd1) : v;
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int roll;
    begin
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
    end
  endfunction

  // Draw one random operand pair, weighted toward pairs with real structure.
  task automatic random_pair(output logic [OPW-1:0] a, output logic [OPW-1:0] b);
    pair_kind_e     kind;
    int unsigned    k;
    int unsigned    n;
    logic [OPW-1:0] g;
    begin
      kind = pair_kind_e'($urandom_range(0, PK_COUNT - 1));
      case (kind)
        PK_COMMON: begin
          // Share a factor of k bits; keep the products inside 62 bits.
          k = $urandom_range(1, 61);
          g = rand64() & low_mask(k);
          a = maybe_negate(g * (rand64() & low_mask(62 - k)));
          b = maybe_negate(g * (rand64() & low_mask(62 - k)));
        end
        PK_MULTIPLE: begin
          b = rand64() & low_mask(31);
          a = maybe_negate(b * (rand64() & low_mask(31)));
          b = maybe_negate(b);
        end
        PK_SMALL: begin
          a = maybe_negate(64'($urandom_range(0, 100)));
          b = maybe_negate(64'($urandom_range(0, 100)));
        end
        PK_CORNER: begin
          a = corner_vals[$urandom_range(0, 6)];
          b = $urandom_range(0, 1) ? corner_vals[$urandom_range(0, 6)] : rand64();
        end
        PK_FIBONACCI: begin
          // Consecutive Fibonacci numbers make Euclid run longest.
          n = $urandom_range(2, 92);
          a = maybe_negate(fib[n]);
          b = maybe_negate(fib[n - 1]);
        end
        PK_SHIFTED: begin
          a = maybe_negate((rand64() & low_mask(20)) << $urandom_range(0, 42));
          b = maybe_negate((rand64() & low_mask(20)) << $urandom_range(0, 42));
        end
        default: begin
          a = rand64();
          b = rand64();
        end
      endcase
      if ($urandom_range(0, 1)) begin
        g = a;
        a = b;
        b = g;
      end
    end
  endtask

  // Offer one item after an optional idle gap; return once it is taken.
  task automatic offer_pair(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                            input bit typed, input logic [DVW-1:0] div);
    int gap;
    begin
      gap = idling_on ? pick_gap() : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid    <= 1'b1;
      operand_a   <= a;
      operand_b   <= b;
      row_typed   <= typed;
      row_divisor <= div;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected divisor has come back.
  task automatic drain_results();
    begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_divisors.size() != 0) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                         input bit typed, input logic [DVW-1:0] div);
    gcd_row_t row;
    begin
      row.a       = a;
      row.b       = b;
      row.typed   = typed;
      row.divisor = div;
      gcd_rows.push_back(row);
    end
  endtask

  // Cycle count and run timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d divisors outstanding", cycles,
             pending_divisors.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls while idling is on; a requested hold-off overrides them.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_seen != hold_asks) begin
        hold_seen  = hold_asks;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap() + 1;
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Scoreboard: check each taken divisor against the oldest expectation,
  // then queue the expectation for each item taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        divisors_seen <= divisors_seen + 1;
        if (pending_divisors.size() == 0) begin
          $error("divisor: unexpected item, actual %0d", divisor);
          mismatches <= mismatches + 1;
        end else begin
          oldest_divisor = pending_divisors.pop_front();
          if (divisor !== oldest_divisor) begin
            $error("divisor: expected %0d, actual %0d", oldest_divisor, divisor);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        items_taken <= items_taken + 1;
        pending_divisors.push_back(row_typed ? row_divisor
                                             : expected_divisor(operand_a, operand_b));
      end
    end
  end

  // Stimulus: directed table, then random phases with drains between them.
  initial begin
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;

    fib[0] = 64'd0;
    fib[1] = 64'd1;
    for (int i = 2; i <= 92; i++) fib[i] = fib[i - 1] + fib[i - 2];
    corner_vals[0] = 64'd0;
    corner_vals[1] = 64'd1;
    corner_vals[2] = MINUS_1;
    corner_vals[3] = POS_MAX;
    corner_vals[4] = NEG_MIN;
    corner_vals[5] = NEG_MAX;
    corner_vals[6] = TWO_P62;

    // Zero operands always give 1.
    add_row(64'd0,    64'd0,    1'b1, DIV_ONE);
    add_row(64'd0,    64'd12,   1'b1, DIV_ONE);
    add_row(-64'sd12, 64'd0,    1'b1, DIV_ONE);
    add_row(POS_MAX,  64'd0,    1'b1, DIV_ONE);
    add_row(NEG_MIN,  64'd0,    1'b1, DIV_ONE);
    // Unit and extreme magnitudes.
    add_row(64'd1,    64'd1,    1'b1, DIV_ONE);
    add_row(MINUS_1,  MINUS_1,  1'b1, DIV_ONE);
    add_row(MINUS_1,  POS_MAX,  1'b1, DIV_ONE);
    add_row(POS_MAX,  64'd1,    1'b1, DIV_ONE);
    add_row(64'd1,    NEG_MIN,  1'b1, DIV_ONE);
    add_row(POS_MAX,  POS_MAX,  1'b1, DIV_MAX);
    add_row(NEG_MAX,  POS_MAX,  1'b1, DIV_MAX);
    // Most negative value saturates to the largest positive magnitude.
    add_row(NEG_MIN,  NEG_MIN,  1'b1, DIV_MAX);
    add_row(NEG_MIN,  POS_MAX,  1'b1, DIV_MAX);
    add_row(NEG_MIN,  TWO_P62,  1'b0, '0);
    // Ordinary pairs, both orders and signs, remainder-one exit, long chains.
    add_row(64'd12,   64'd18,   1'b0, '0);
    add_row(-64'sd12, 64'd18,   1'b0, '0);
    add_row(64'd18,   -64'sd12, 1'b0, '0);
    add_row(64'd7,    64'd3,    1'b0, '0);
    add_row(64'd6,    64'd6,    1'b0, '0);
    add_row(POS_MAX,  POS_MAX - 64'd1, 1'b0, '0);
    add_row(fib[92],  fib[91],  1'b0, '0);
    add_row(TWO_P62,  64'h2000_0000_0000_0000, 1'b0, '0);
    add_row(~TWO_P62 + 64'd1, 64'h0000_0300_0000_0000, 1'b0, '0);
    add_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idling_on = 1'b1;
    foreach (gcd_rows[i]) offer_pair(gcd_rows[i].a, gcd_rows[i].b, gcd_rows[i].typed,
                                     gcd_rows[i].divisor);
    drain_results();

    // Quiet phase runs with no idling; hold phase keeps offering back to back
    // while the receiver holds off, so the block fills and stalls its input.
    for (int phase = 0; phase < PHASES; phase++) begin
      idling_on = (phase != QUIET_PHASE) && (phase != HOLD_PHASE);
      if (phase == HOLD_PHASE) hold_asks = hold_asks + 1;
      repeat (PAIRS_PER) begin
        random_pair(a, b);
        offer_pair(a, b, 1'b0, '0);
      end
      drain_results();
    end

    // Let any stray result surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d directed pairs and %0d random pairs over %0d phases",
             gcd_rows.size(), PHASES * PAIRS_PER, PHASES);
    $display("%0d items taken, %0d divisors checked, %0d receiver hold-off(s), %0d cycles",
             items_taken, divisors_seen, hold_asks, cycles);
    if (mismatches == 0 && pending_divisors.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sgcd_pkg.sv
hw/rtl/sgcd_abs.sv
hw/rtl/sgcd_sub.sv
hw/rtl/sgcd_core.sv
hw/rtl/signed_integer_gcd.sv
tb/signed_integer_gcd_tb.sv
